>>> hw/rtl/mpc_pkg.sv
// Package: sizes, state encoding and field types for the map page cache.
package mpc_pkg;
    localparam int SLOTS           = 64;
    localparam int MAPS            = 4096;
    localparam int ENTRIES_PER_MAP = 512;
    localparam int SLOT_W          = $clog2(SLOTS);
    localparam int MAP_W           = $clog2(MAPS);
    localparam int EPM_W           = $clog2(ENTRIES_PER_MAP);
    localparam int KEY_W           = MAP_W + 1;
    localparam int KEYS            = 2 * MAPS;
    localparam int PAGE_W          = 21;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_CHECK,
        ST_SWEEP,
        ST_EVICT,
        ST_INSTALL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              func;
        logic              map_kind;
        logic [PAGE_W-1:0] page_number;
    } req_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              victim_valid;
        logic              victim_kind;
        logic [MAP_W-1:0]  victim_map;
        logic              writeback;
    } rsp_t;
endpackage

>>> hw/rtl/mpc_stream_if.sv
// Interface: valid/ready channel carrying one packed payload.
interface mpc_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/map_page_cache_clock_unit.sv
// Top level: map page cache with CLOCK second-chance replacement.
// Hit path: IDLE (accept), LOOKUP, CHECK, DONE; a miss adds SWEEP, EVICT and
// INSTALL, the sweep testing one slot reference bit per cycle until one is clear.
// Throughput: one transaction at a time; next accepted after result taken.
// Reset: async active low; then a clearing pass over all KEYS entries of the
// cached-flag memory, during which no transaction is accepted.
module map_page_cache_clock_unit (
    input  logic clk,
    input  logic rst_n,
    mpc_stream_if.sink   req,
    mpc_stream_if.source rsp
);
    import mpc_pkg::*;

    // Per-slot tag state: map number in a small RAM, status bits in flops.
    logic [MAP_W-1:0]  slot_map_mem [SLOTS];
    logic [MAP_W-1:0]  slot_map_rd_reg;
    logic [SLOTS-1:0]  slot_kind_reg;
    logic [SLOTS-1:0]  slot_valid_reg;
    logic [SLOTS-1:0]  slot_ref_reg;
    logic [SLOTS-1:0]  slot_dirty_reg;
    logic [SLOT_W-1:0] hand_reg;

    // Per-key memories: cached flag and slot pointer.
    logic              cached_mem [KEYS];
    logic [SLOT_W-1:0] mslot_mem  [KEYS];
    logic              cached_rd_reg;
    logic [SLOT_W-1:0] mslot_rd_reg;

    state_t state_reg, state_next;
    logic [KEY_W-1:0]  clr_reg;
    logic              func_reg, kind_reg;
    logic [MAP_W-1:0]  mapn_reg;
    logic [SLOT_W-1:0] s_reg;
    rsp_t              out_reg;
    logic              out_valid_reg;

    logic [KEY_W-1:0]  key, okey, rd_key;
    logic [SLOT_W-1:0] map_rd_addr;
    logic              hit;
    logic              mem_we;
    logic [KEY_W-1:0]  mem_addr;
    logic              mem_wd;

    assign key  = {kind_reg, mapn_reg};
    // In idle the key memories are read straight from the incoming request,
    // so the pointer is ready in LOOKUP for the tag read.
    assign rd_key = (state_reg == ST_IDLE)
                    ? {req.data.map_kind, req.data.page_number[EPM_W +: MAP_W]} : key;
    // Tag RAM address: the hand during the sweep (victim tag ready in EVICT),
    // else the cached slot pointer (tag ready in CHECK).
    assign map_rd_addr = (state_reg == ST_SWEEP) ? hand_reg : mslot_rd_reg;
    assign okey = {slot_kind_reg[s_reg], slot_map_rd_reg};
    assign hit  = cached_rd_reg && slot_valid_reg[mslot_rd_reg]
                  && slot_kind_reg[mslot_rd_reg] == kind_reg
                  && slot_map_rd_reg == mapn_reg;

    assign req.ready = (state_reg == ST_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:   if (clr_reg == KEY_W'(KEYS - 1)) state_next = ST_IDLE;
            ST_IDLE:    if (req.valid) state_next = ST_LOOKUP;
            ST_LOOKUP:  state_next = ST_CHECK;
            ST_CHECK:   state_next = hit ? ST_DONE : ST_SWEEP;
            ST_SWEEP:   if (!slot_ref_reg[hand_reg]) state_next = ST_EVICT;
            ST_EVICT:   state_next = ST_INSTALL;
            ST_INSTALL: state_next = ST_DONE;
            ST_DONE:    if (out_valid_reg && rsp.ready) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Cached-flag memory port control.
    always_comb
    begin
        mem_we   = 1'b0;
        mem_addr = key;
        mem_wd   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_addr = clr_reg;
            end
            ST_EVICT:
            begin
                mem_we   = slot_valid_reg[s_reg];
                mem_addr = okey;
            end
            ST_INSTALL:
            begin
                mem_we = 1'b1;
                mem_wd = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            cached_mem[mem_addr] <= mem_wd;
        if (state_reg == ST_INSTALL)
        begin
            mslot_mem[key]      <= s_reg;
            slot_map_mem[s_reg] <= mapn_reg;
        end
        cached_rd_reg   <= cached_mem[rd_key];
        mslot_rd_reg    <= mslot_mem[rd_key];
        slot_map_rd_reg <= slot_map_mem[map_rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            hand_reg       <= '0;
            slot_valid_reg <= '0;
            slot_ref_reg   <= '0;
            slot_dirty_reg <= '0;
            slot_kind_reg  <= '0;
            func_reg       <= 1'b0;
            kind_reg       <= 1'b0;
            mapn_reg       <= '0;
            s_reg          <= '0;
            out_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (rsp.valid && rsp.ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_CLEAR: clr_reg <= clr_reg + 1'b1;
                ST_IDLE:
                    if (req.valid)
                    begin
                        func_reg <= req.data.func;
                        kind_reg <= req.data.map_kind;
                        mapn_reg <= req.data.page_number[EPM_W +: MAP_W];
                    end
                ST_CHECK:
                begin
                    out_reg.hit          <= hit;
                    out_reg.slot         <= hit ? mslot_rd_reg : '0;
                    out_reg.victim_valid <= 1'b0;
                    out_reg.victim_kind  <= 1'b0;
                    out_reg.victim_map   <= '0;
                    out_reg.writeback    <= 1'b0;
                    if (hit)
                    begin
                        slot_ref_reg[mslot_rd_reg] <= 1'b1;
                        if (func_reg)
                            slot_dirty_reg[mslot_rd_reg] <= 1'b1;
                    end
                end
                ST_SWEEP:
                begin
                    // hand wraps naturally: SLOTS is a power of two
                    hand_reg <= hand_reg + 1'b1;
                    s_reg    <= hand_reg;
                    slot_ref_reg[hand_reg] <= 1'b0;
                end
                ST_EVICT:
                begin
                    out_reg.slot <= s_reg;
                    if (slot_valid_reg[s_reg])
                    begin
                        out_reg.victim_valid <= 1'b1;
                        out_reg.victim_kind  <= slot_kind_reg[s_reg];
                        out_reg.victim_map   <= slot_map_rd_reg;
                        out_reg.writeback    <= slot_dirty_reg[s_reg];
                    end
                end
                ST_INSTALL:
                begin
                    slot_kind_reg[s_reg]  <= kind_reg;
                    slot_valid_reg[s_reg] <= 1'b1;
                    slot_ref_reg[s_reg]   <= 1'b1;
                    slot_dirty_reg[s_reg] <= func_reg;
                end
                ST_DONE:
                    if (!out_valid_reg)
                        out_valid_reg <= 1'b1;
                default: ;
            endcase
        end
    end
endmodule

>>> sim/testbench.sv
// Testbench for the map page cache: random and directed requests checked against a predictor.
`timescale 1ns / 100ps

module testbench;
    import mpc_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    mpc_stream_if #(.payload_t(req_t)) req_ch ();
    mpc_stream_if #(.payload_t(rsp_t)) rsp_ch ();

    map_page_cache_clock_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    always #5 clk = ~clk;

    // Predictor state: shadow copy of the cache tags and the per-kind map table.
    logic [MAP_W-1:0]  shadow_map_number [SLOTS];
    logic              shadow_kind [SLOTS];
    logic              shadow_valid [SLOTS];
    logic              shadow_reference [SLOTS];
    logic              shadow_dirty [SLOTS];
    logic              shadow_cached [KEYS];
    logic [SLOT_W-1:0] shadow_map_slot [KEYS];
    logic [SLOT_W-1:0] shadow_hand;

    req_t pending_requests [$];
    rsp_t expected_responses [$];
    int   error_count = 0;
    int   cycle_count = 0;
    bit   stimulus_done = 1'b0;
    bit   calm_window;            // no idling on either side while set

    localparam int CYCLE_LIMIT = 1000000;

    // Predict one response and advance the shadow state.
    function automatic rsp_t predict_lookup(req_t r);
        rsp_t              o;
        logic [MAP_W-1:0]  mapn;
        logic [KEY_W-1:0]  key;
        logic [SLOT_W-1:0] s;
        logic              is_hit;
        o = '0;
        mapn = MAP_W'(r.page_number / ENTRIES_PER_MAP);
        key = {r.map_kind, mapn};
        is_hit = 1'b0;
        s = '0;
        if (shadow_cached[key])
        begin
            s = shadow_map_slot[key];
            is_hit = shadow_valid[s] && shadow_kind[s] == r.map_kind
                     && shadow_map_number[s] == mapn;
        end
        if (is_hit)
        begin
            shadow_reference[s] = 1'b1;
            if (r.func)
                shadow_dirty[s] = 1'b1;
        end
        else
        begin
            // CLOCK sweep: clear reference bits until a clear one is met
            while (shadow_reference[shadow_hand])
            begin
                shadow_reference[shadow_hand] = 1'b0;
                shadow_hand++;
            end
            s = shadow_hand;
            shadow_hand++;
            if (shadow_valid[s])
            begin
                o.victim_valid = 1'b1;
                o.victim_kind  = shadow_kind[s];
                o.victim_map   = shadow_map_number[s];
                o.writeback    = shadow_dirty[s];
                shadow_cached[{shadow_kind[s], shadow_map_number[s]}] = 1'b0;
            end
            shadow_map_number[s] = mapn;
            shadow_kind[s]       = r.map_kind;
            shadow_valid[s]      = 1'b1;
            shadow_reference[s]  = 1'b1;
            shadow_dirty[s]      = r.func;
            shadow_cached[key]   = 1'b1;
            shadow_map_slot[key] = s;
        end
        o.hit = is_hit;
        o.slot = s;
        return o;
    endfunction

    function automatic req_t make_req(logic f, logic k, logic [PAGE_W-1:0] p);
        req_t r;
        r.func = f;
        r.map_kind = k;
        r.page_number = p;
        return r;
    endfunction

    // Random page biased toward a small working set so hits and evictions both occur.
    function automatic logic [PAGE_W-1:0] random_page();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 45)
            return PAGE_W'($urandom_range(0, 47) * ENTRIES_PER_MAP + $urandom_range(0, 511));
        else if (sel < 75)
            return PAGE_W'($urandom_range(0, 99) * ENTRIES_PER_MAP + $urandom_range(0, 511));
        else
            return PAGE_W'($urandom);
    endfunction

    // Driver: one request transaction at a time from the pending queue.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.data  <= '0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
                expected_responses.push_back(predict_lookup(req_ch.data));
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending_requests.size() > 0
                    && (calm_window || $urandom_range(0, 99) >= 13))
                begin
                    req_ch.valid <= 1'b1;
                    req_ch.data  <= pending_requests.pop_front();
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: random backpressure and field-by-field compare.
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t exp_rsp;
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_responses.size() == 0)
                begin
                    $error("unexpected response transaction");
                    error_count++;
                end
                else
                begin
                    exp_rsp = expected_responses.pop_front();
                    if (rsp_ch.data.hit !== exp_rsp.hit)
                    begin
                        $error("hit: expected %0d actual %0d", exp_rsp.hit, rsp_ch.data.hit);
                        error_count++;
                    end
                    if (rsp_ch.data.slot !== exp_rsp.slot)
                    begin
                        $error("slot: expected %0d actual %0d", exp_rsp.slot, rsp_ch.data.slot);
                        error_count++;
                    end
                    if (rsp_ch.data.victim_valid !== exp_rsp.victim_valid)
                    begin
                        $error("victim_valid: expected %0d actual %0d",
                               exp_rsp.victim_valid, rsp_ch.data.victim_valid);
                        error_count++;
                    end
                    if (rsp_ch.data.victim_kind !== exp_rsp.victim_kind)
                    begin
                        $error("victim_kind: expected %0d actual %0d",
                               exp_rsp.victim_kind, rsp_ch.data.victim_kind);
                        error_count++;
                    end
                    if (rsp_ch.data.victim_map !== exp_rsp.victim_map)
                    begin
                        $error("victim_map: expected %0d actual %0d",
                               exp_rsp.victim_map, rsp_ch.data.victim_map);
                        error_count++;
                    end
                    if (rsp_ch.data.writeback !== exp_rsp.writeback)
                    begin
                        $error("writeback: expected %0d actual %0d",
                               exp_rsp.writeback, rsp_ch.data.writeback);
                        error_count++;
                    end
                end
            end
            rsp_ch.ready <= calm_window || $urandom_range(0, 99) >= 13;
        end
    end

    // Watchdog: cycle counter with a generous limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Calm window somewhere in the middle of the random part.
    always @(posedge clk)
        calm_window <= (pending_requests.size() > 150 && pending_requests.size() < 250);

    initial
    begin
        int i;
        for (i = 0; i < SLOTS; i++)
        begin
            shadow_map_number[i] = '0;
            shadow_kind[i]       = 1'b0;
            shadow_valid[i]      = 1'b0;
            shadow_reference[i]  = 1'b0;
            shadow_dirty[i]      = 1'b0;
        end
        for (i = 0; i < KEYS; i++)
        begin
            shadow_cached[i]   = 1'b0;
            shadow_map_slot[i] = '0;
        end
        shadow_hand = '0;

        // Directed: field extremes, both kinds, both functions.
        pending_requests.push_back(make_req(1'b0, 1'b0, '0));            // empty-slot miss
        pending_requests.push_back(make_req(1'b0, 1'b0, 21'd511));       // hit, same map
        pending_requests.push_back(make_req(1'b1, 1'b0, 21'd5));         // update marks dirty
        pending_requests.push_back(make_req(1'b0, 1'b1, '0));            // same map, other kind
        pending_requests.push_back(make_req(1'b1, 1'b1, 21'h1FFFFF));    // top page, top map
        pending_requests.push_back(make_req(1'b0, 1'b0, 21'h1FFFFF));
        pending_requests.push_back(make_req(1'b0, 1'b0, PAGE_W'(4096 * 512))); // wraps onto map 0
        pending_requests.push_back(make_req(1'b1, 1'b1, 21'd512));
        pending_requests.push_back(make_req(1'b0, 1'b1, 21'h0AAAAA));
        pending_requests.push_back(make_req(1'b1, 1'b0, 21'h155555));
        // Fourteen distinct maps of both kinds and functions, then random requests that overflow the slots.
        for (i = 0; i < 14; i++)
            pending_requests.push_back(make_req(i[0], i[1], PAGE_W'((i + 10) * 4 * 512)));
        for (i = 0; i < 400; i++)
            pending_requests.push_back(make_req(1'($urandom_range(0, 1)),
                                                1'($urandom_range(0, 1)),
                                                random_page()));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_requests.size() == 0 && !req_ch.valid);
        wait (expected_responses.size() == 0);
        repeat (SLOTS * 2 + 20) @(posedge clk);
        if (error_count == 0 && expected_responses.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

>>> sim.f
hw/rtl/mpc_pkg.sv
hw/rtl/mpc_stream_if.sv
hw/rtl/map_page_cache_clock_unit.sv
sim/testbench.sv
